FILE: design/multichannel_tick_pwm_generator_macros.svh
// Assertion macros for the tick PWM generator.
// Used by the top level only; no other dependencies.
`ifndef MULTICHANNEL_TICK_PWM_GENERATOR_MACROS_SVH
`define MULTICHANNEL_TICK_PWM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCTP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MCTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mctp_pkg.sv
// Shared types, widths and codes for the tick PWM generator.
// No dependencies; imported by every module of the block.
package mctp_pkg;

  localparam int CHANNELS   = 4;
  localparam int TICK_WIDTH = 32;
  localparam int PCT_FULL   = 100;
  localparam int VIS_CH     = 4;   // channels visible in the result

  localparam int REQ_W   = 2;
  localparam int CHAN_W  = 3;
  localparam int FREQ_W  = 20;
  localparam int DUTY_W  = 8;
  localparam int STAT_W  = 3;
  localparam int CLK_W   = 27;
  localparam int PRESC_W = 11;
  localparam int PCT_W   = 7;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 27;

  localparam int NUM_W = CLK_W + PCT_W;
  localparam int PF_W  = PRESC_W + FREQ_W;
  localparam int DEN_W = PF_W + PCT_W;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_INIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_CHANNEL = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUTY_RANGE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RUNNING     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_RUNNING = 3'd5;
  localparam logic [STAT_W-1:0] ST_ZERO_FREQ   = 3'd6;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ENABLE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_CLOCK_HZ = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PRESCALE = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MIN_DUTY = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MAX_DUTY = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAN_W-1:0] channel;
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_pct;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VIS_CH-1:0] pin_levels;
    logic [VIS_CH-1:0] running_mask;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture the request
    logic mul;        // register numerators and prescale*freq
    logic den;        // register the denominator
    logic div_start;  // launch both dividers
    logic exec;       // apply a request that needs no division
    logic load;       // write the computed counts, start the channel
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

FILE: design/mctp_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on mctp_pkg for the operand widths.
module mctp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [mctp_pkg::NUM_W-1:0] dividend,
  input  logic [mctp_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [mctp_pkg::NUM_W-1:0] quotient
);
  import mctp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == CNT_W'(1));
      if (go) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  // dividend bits shift out of the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
    end else if (active) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: design/mctp_ctrl.sv
// Request sequencer for the tick PWM generator.
// Depends on mctp_pkg for the command and status structs.
module mctp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mctp_pkg::dp_stat_t   stat,
  output mctp_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 result_valid
);
  import mctp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_DEN   = 6'b000100,
    S_DIVGO = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
        if (start) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.mul = 1'b1;
        if (stat.need_div) begin
          state_next = S_DEN;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DEN: begin
        cmd.den    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);

endmodule

FILE: design/mctp_dp.sv
// Datapath: config registers, request checks, tick counters, count math.
// Depends on mctp_pkg and on mctp_div (two instances, on and off counts).
module mctp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mctp_pkg::req_t                request,
  input  mctp_pkg::ctrl_cmd_t           cmd,
  output mctp_pkg::dp_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [mctp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mctp_pkg::CDATA_W-1:0]  cfg_data,
  output mctp_pkg::rsp_t                result
);
  import mctp_pkg::*;

  localparam int PAD_W = (CHANNELS > VIS_CH) ? CHANNELS : VIS_CH;
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

  // configuration
  logic               mod_en;
  logic [CLK_W-1:0]   clock_hz;
  logic [PRESC_W-1:0] prescale;
  logic [PCT_W-1:0]   min_duty;
  logic [PCT_W-1:0]   max_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_en   <= 1'b0;
      clock_hz <= CLK_W'(8000000);
      prescale <= PRESC_W'(8);
      min_duty <= PCT_W'(0);
      max_duty <= PCT_W'(PCT_FULL);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:   mod_en   <= cfg_data[0];
        CFG_CLOCK_HZ: clock_hz <= cfg_data[CLK_W-1:0];
        CFG_PRESCALE: prescale <= cfg_data[PRESC_W-1:0];
        CFG_MIN_DUTY: min_duty <= cfg_data[PCT_W-1:0];
        CFG_MAX_DUTY: max_duty <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // request and channel state
  req_t                req_q;
  logic [STAT_W-1:0]   st_q;
  logic [CHANNELS-1:0] pin;
  logic [CHANNELS-1:0] running;
  logic [CHANNELS-1:0] next_low;
  logic [TICK_WIDTH-1:0] high_ticks [CHANNELS];
  logic [TICK_WIDTH-1:0] low_ticks  [CHANNELS];
  logic [TICK_WIDTH-1:0] remaining  [CHANNELS];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= request;
    end
  end

  // request checks, evaluated while the request sits in req_q
  logic [CHANNELS-1:0] sel;
  logic                sel_running;
  logic [STAT_W-1:0]   chk_code;
  logic                act_tick;
  logic                act_pin_high;
  logic                act_stop;
  logic                need_div;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sel[c] = ({1'b0, req_q.channel} == (CHAN_W + 1)'(c));
    end
    sel_running  = |(sel & running);
    chk_code     = ST_OK;
    act_tick     = 1'b0;
    act_pin_high = 1'b0;
    act_stop     = 1'b0;
    need_div     = 1'b0;
    if (req_q.req_type == REQ_NONE) begin
      chk_code = ST_OK;
    end else if (!mod_en) begin
      chk_code = ST_NOT_INIT;
    end else if (req_q.req_type == REQ_TICK) begin
      act_tick = 1'b1;
    end else if ({1'b0, req_q.channel} >= CH_LIMIT) begin
      chk_code = ST_BAD_CHANNEL;
    end else if (req_q.req_type == REQ_START) begin
      if (req_q.duty_pct > {1'b0, max_duty} || req_q.duty_pct < {1'b0, min_duty}) begin
        chk_code = ST_DUTY_RANGE;
      end else if (sel_running) begin
        chk_code = ST_RUNNING;
      end else if (req_q.duty_pct == '0) begin
        chk_code = ST_OK;
      end else if (req_q.duty_pct >= DUTY_W'(PCT_FULL)) begin
        act_pin_high = 1'b1;
      end else if (req_q.freq_hz == '0) begin
        chk_code = ST_ZERO_FREQ;
      end else begin
        need_div = 1'b1;
      end
    end else if (!sel_running) begin
      chk_code = ST_NOT_RUNNING;
    end else begin
      act_stop = 1'b1;
    end
  end

  // count math: on = clock*duty / (100*prescale*freq), off likewise
  logic [PCT_W-1:0]   on_pct;
  logic [PCT_W-1:0]   off_pct;
  logic [PRESC_W-1:0] presc_eff;
  logic [NUM_W-1:0]   num_hi;
  logic [NUM_W-1:0]   num_lo;
  logic [PF_W-1:0]    pf;
  logic [DEN_W-1:0]   den;

  assign on_pct    = req_q.duty_pct[PCT_W-1:0];
  assign off_pct   = PCT_W'(DUTY_W'(PCT_FULL) - req_q.duty_pct);
  assign presc_eff = (prescale == '0) ? PRESC_W'(1) : prescale;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_hi <= NUM_W'(clock_hz) * NUM_W'(on_pct);
      num_lo <= NUM_W'(clock_hz) * NUM_W'(off_pct);
      pf     <= PF_W'(presc_eff) * PF_W'(req_q.freq_hz);
    end
    if (cmd.den) begin
      den <= DEN_W'(pf) * DEN_W'(PCT_FULL);
    end
  end

  logic [NUM_W-1:0] q_hi;
  logic [NUM_W-1:0] q_lo;
  logic             done_hi;
  logic             done_lo;

  mctp_div u_div_hi (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_start),
    .dividend (num_hi),
    .divisor  (den),
    .done     (done_hi),
    .quotient (q_hi)
  );

  mctp_div u_div_lo (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_start),
    .dividend (num_lo),
    .divisor  (den),
    .done     (done_lo),
    .quotient (q_lo)
  );

  // clamp to 1 .. 2^TICK_WIDTH-1
  function automatic logic [TICK_WIDTH-1:0] sat_ticks(input logic [NUM_W-1:0] q);
    logic [TICK_WIDTH-1:0] r;
    if (|q[NUM_W-1:TICK_WIDTH]) begin
      r = '1;
    end else if (q == '0) begin
      r = TICK_WIDTH'(1);
    end else begin
      r = q[TICK_WIDTH-1:0];
    end
    return r;
  endfunction

  logic [TICK_WIDTH-1:0] hi_sat;
  logic [TICK_WIDTH-1:0] lo_sat;

  assign hi_sat = sat_ticks(q_hi);
  assign lo_sat = sat_ticks(q_lo);

  // per-channel control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pin      <= '0;
      running  <= '0;
      next_low <= '0;
      st_q     <= ST_OK;
    end else begin
      if (cmd.exec) begin
        st_q <= chk_code;
      end else if (cmd.load) begin
        st_q <= ST_OK;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (cmd.exec && act_tick && running[c] && remaining[c] <= TICK_WIDTH'(1)) begin
          pin[c]      <= ~pin[c];
          next_low[c] <= ~next_low[c];
        end
        if (cmd.exec && act_pin_high && sel[c]) begin
          pin[c] <= 1'b1;
        end
        if (cmd.exec && act_stop && sel[c]) begin
          pin[c]     <= 1'b0;
          running[c] <= 1'b0;
        end
        if (cmd.load && sel[c]) begin
          pin[c]      <= 1'b1;
          running[c]  <= 1'b1;
          next_low[c] <= 1'b1;
        end
      end
    end
  end

  // per-channel tick counts
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd.exec && act_tick && running[c]) begin
        if (remaining[c] > TICK_WIDTH'(1)) begin
          remaining[c] <= remaining[c] - TICK_WIDTH'(1);
        end else begin
          remaining[c] <= next_low[c] ? low_ticks[c] : high_ticks[c];
        end
      end
      if (cmd.load && sel[c]) begin
        high_ticks[c] <= hi_sat;
        low_ticks[c]  <= lo_sat;
        remaining[c]  <= hi_sat;
      end
    end
  end

  logic [PAD_W-1:0] pin_pad;
  logic [PAD_W-1:0] run_pad;

  assign pin_pad = PAD_W'(pin);
  assign run_pad = PAD_W'(running);

  assign result.status       = st_q;
  assign result.pin_levels   = pin_pad[VIS_CH-1:0];
  assign result.running_mask = run_pad[VIS_CH-1:0];

  assign stat.need_div = need_div;
  assign stat.div_done = done_hi & done_lo;

endmodule

FILE: design/multichannel_tick_pwm_generator.sv
// Top level of the multichannel tick PWM generator.
// Depends on mctp_pkg, mctp_ctrl, mctp_dp and the assertion macro header.
//
// Usage:
//   Requests enter on request when start is high and busy is low. Kinds are
//   start channel, stop channel, timer tick and none; each gives exactly one
//   result on result, marked by a one-cycle result_valid strobe. The result
//   carries a status code and the pin level and running flag of channels 0..3
//   after the request. There is no back-pressure on results.
//   Configuration is written on cfg_valid/cfg_index/cfg_data; cfg_ready is
//   always high. Write only while busy is low.
// Sequence:
//   Requests that need no division (stop, tick, none, rejected, and zero- or
//   full-duty starts) pass EVAL, then DONE, where result_valid is raised;
//   busy drops on the return to IDLE, and only then is a new request taken.
//   Start that loads counts: EVAL, DEN, DIVGO, DIV (two parallel serial dividers,
//   one quotient bit per cycle over a 34-bit dividend), then DONE and IDLE.
// Reset:
//   rst (synchronous) restores register defaults, stops every channel and
//   drives all pins low. Stored tick counts are not cleared.
module multichannel_tick_pwm_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mctp_pkg::req_t                request,
  output logic                          result_valid,
  output mctp_pkg::rsp_t                result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mctp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mctp_pkg::CDATA_W-1:0]  cfg_data
);
  import mctp_pkg::*;
`include "multichannel_tick_pwm_generator_macros.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  mctp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  mctp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // an accepted request keeps the block busy until its result is out
  `MCTP_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  `MCTP_ASSERT_NEXT(a_single_strobe, clk, rst, result_valid, !result_valid && !busy, "result strobe longer than one cycle")
  `MCTP_ASSERT_NOW(a_status_legal, clk, rst, result_valid, result.status <= ST_ZERO_FREQ, "undefined status code")
  `MCTP_ASSERT_NOW(a_load_once, clk, rst, cmd.load || cmd.exec, !(cmd.load && cmd.exec), "exec and load together")

endmodule

FILE: bench/multichannel_tick_pwm_generator_tb.sv
// Self-checking bench for the multichannel tick PWM generator.
// Needs mctp_pkg and the top level; predicts status, pin levels and run flags.
`timescale 1ns / 1ps

module multichannel_tick_pwm_generator_tb;
  import mctp_pkg::*;

  typedef struct {
    req_t req;
    bit   settle;  // hold this request until every result is back
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic result_valid;
  rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;

  pend_t req_backlog[$];
  rsp_t rsp_due[$];
  pend_t next_req;
  bit in_flight = 1'b0;
  int idle_pct = 0;
  int mismatches = 0;

  // predictor copy of the block
  bit cfg_en = 1'b0;
  logic [CLK_W-1:0] cfg_clk_hz = 27'd8000000;
  logic [PRESC_W-1:0] cfg_presc = 11'd8;
  logic [PCT_W-1:0] cfg_min = 7'd0;
  logic [PCT_W-1:0] cfg_max = 7'd100;
  bit pin_q[CHANNELS] = '{default: 1'b0};
  bit run_q[CHANNELS] = '{default: 1'b0};
  bit low_next[CHANNELS] = '{default: 1'b0};
  logic [TICK_WIDTH-1:0] on_ticks[CHANNELS];
  logic [TICK_WIDTH-1:0] off_ticks[CHANNELS];
  logic [TICK_WIDTH-1:0] left_ticks[CHANNELS];

  multichannel_tick_pwm_generator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [TICK_WIDTH-1:0] period_ticks(input logic [DUTY_W-1:0] pct,
                                                          input logic [FREQ_W-1:0] freq);
    logic [63:0] num, den, q, lim;
    num = 64'(cfg_clk_hz) * 64'(pct);
    den = 64'(PCT_FULL) * 64'((cfg_presc == 0) ? 11'd1 : cfg_presc) * 64'(freq);
    lim = (64'd1 << TICK_WIDTH) - 64'd1;
    q = num / den;
    if (q > lim) q = lim;
    if (q < 64'd1) q = 64'd1;
    return q[TICK_WIDTH-1:0];
  endfunction

  function automatic rsp_t pwm_predict(input req_t r);
    rsp_t o;
    int ch;
    ch = int'(r.channel);
    o = '0;
    o.status = ST_OK;
    if (r.req_type == REQ_NONE) begin
      o.status = ST_OK;
    end else if (!cfg_en) begin
      o.status = ST_NOT_INIT;
    end else if (r.req_type == REQ_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (run_q[c]) begin
          if (left_ticks[c] > 1) begin
            left_ticks[c] = left_ticks[c] - 1;
          end else begin
            pin_q[c] = ~pin_q[c];
            left_ticks[c] = low_next[c] ? off_ticks[c] : on_ticks[c];
            low_next[c] = ~low_next[c];
          end
        end
      end
    end else if (ch >= CHANNELS) begin
      o.status = ST_BAD_CHANNEL;
    end else if (r.req_type == REQ_START) begin
      if (r.duty_pct > cfg_max || r.duty_pct < cfg_min) begin
        o.status = ST_DUTY_RANGE;
      end else if (run_q[ch]) begin
        o.status = ST_RUNNING;
      end else if (r.duty_pct == 0) begin
        o.status = ST_OK;
      end else if (r.duty_pct >= PCT_FULL) begin
        pin_q[ch] = 1'b1;  // full duty: pin high, channel not running
      end else if (r.freq_hz == 0) begin
        o.status = ST_ZERO_FREQ;
      end else begin
        on_ticks[ch] = period_ticks(r.duty_pct, r.freq_hz);
        off_ticks[ch] = period_ticks(DUTY_W'(PCT_FULL) - r.duty_pct, r.freq_hz);
        left_ticks[ch] = on_ticks[ch];
        low_next[ch] = 1'b1;
        pin_q[ch] = 1'b1;
        run_q[ch] = 1'b1;
      end
    end else if (!run_q[ch]) begin
      o.status = ST_NOT_RUNNING;
    end else begin
      pin_q[ch] = 1'b0;
      run_q[ch] = 1'b0;
    end
    for (int c = 0; c < VIS_CH && c < CHANNELS; c++) begin
      o.pin_levels[c] = pin_q[c];
      o.running_mask[c] = run_q[c];
    end
    return o;
  endfunction

  // driver: record acceptance at the rising edge, present the next request at the falling edge
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      rsp_due.push_back(pwm_predict(request));
      in_flight = 1'b0;
    end
    @(negedge clk);
    if (!in_flight) begin
      if (req_backlog.size() != 0 && !(req_backlog[0].settle && rsp_due.size() != 0) &&
          $urandom_range(99) >= idle_pct) begin
        next_req = req_backlog.pop_front();
        request <= next_req.req;
        start <= 1'b1;
        in_flight = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && result_valid) begin
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d pins %b run %b", $realtime,
                   result.status, result.pin_levels, result.running_mask);
      end else begin
        want = rsp_due.pop_front();
        if (result.status !== want.status || result.pin_levels !== want.pin_levels ||
            result.running_mask !== want.running_mask) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch status %0d/%0d pins %b/%b run %b/%b (exp/act)",
                     $realtime, want.status, result.status, want.pin_levels,
                     result.pin_levels, want.running_mask, result.running_mask);
        end
      end
    end
  end

  task automatic wait_quiet();
    do @(posedge clk);
    while (req_backlog.size() != 0 || in_flight || rsp_due.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_ENABLE:   cfg_en = val[0];
      CFG_CLOCK_HZ: cfg_clk_hz = val[CLK_W-1:0];
      CFG_PRESCALE: cfg_presc = val[PRESC_W-1:0];
      CFG_MIN_DUTY: cfg_min = val[PCT_W-1:0];
      CFG_MAX_DUTY: cfg_max = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input bit en, input int unsigned chz, input int unsigned presc,
                                input int unsigned mn, input int unsigned mx);
    wait_quiet();
    write_reg(CFG_ENABLE, CDATA_W'(en));
    write_reg(CFG_CLOCK_HZ, CDATA_W'(chz));
    write_reg(CFG_PRESCALE, CDATA_W'(presc));
    write_reg(CFG_MIN_DUTY, CDATA_W'(mn));
    write_reg(CFG_MAX_DUTY, CDATA_W'(mx));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_req(input logic [REQ_W-1:0] kind, input int unsigned ch,
                          input int unsigned f, input int unsigned d, input bit settle);
    pend_t p;
    p.req.req_type = kind;
    p.req.channel = CHAN_W'(ch);
    p.req.freq_hz = FREQ_W'(f);
    p.req.duty_pct = DUTY_W'(d);
    p.settle = settle;
    req_backlog.push_back(p);
  endtask

  function automatic logic [REQ_W-1:0] pick_req_kind();
    return REQ_W'($urandom_range(3));
  endfunction

  task automatic run_phase(input bit en, input int unsigned chz, input int unsigned presc,
                           input int unsigned mn, input int unsigned mx, input int idle,
                           input int n);
    longint unsigned base, lo, hi;
    int unsigned sel, f, fsel;
    apply_settings(en, chz, presc, mn, mx);
    idle_pct = idle;
    // frequency band that gives periods of a few dozen ticks at most
    base = chz / ((presc == 0) ? 1 : presc);
    lo = base / 40;
    hi = base / 2;
    if (hi > 1000000) hi = 1000000;
    if (lo > hi) lo = hi;
    if (lo == 0) lo = 1;
    if (hi < lo) hi = lo;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      fsel = $urandom_range(99);
      if (fsel < 85) f = $urandom_range(int'(lo), int'(hi));
      else if (fsel < 95) f = $urandom_range(1000000);
      else f = 0;
      if (sel < 40)
        push_req(REQ_TICK, $urandom_range(7), $urandom_range(1000000), $urandom_range(255),
                 i % 60 == 59);
      else if (sel < 65)
        push_req(REQ_START, $urandom_range(CHANNELS - 1), f,
                 ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(mn, mx),
                 i % 60 == 59);
      else if (sel < 80)
        push_req(REQ_STOP, $urandom_range(CHANNELS - 1), $urandom_range(1000000),
                 $urandom_range(255), i % 60 == 59);
      else
        push_req(pick_req_kind(), $urandom_range(7), f, $urandom_range(255), i % 60 == 59);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // module still disabled after reset
    push_req(REQ_START, 0, 100, 50, 1'b0);
    push_req(REQ_STOP, 0, 0, 0, 1'b0);
    push_req(REQ_TICK, 0, 0, 0, 1'b0);
    push_req(REQ_NONE, 7, 1048575, 255, 1'b0);

    apply_settings(1'b1, 1000, 1, 0, 100);
    push_req(REQ_START, 0, 100, 50, 1'b0);
    push_req(REQ_START, 0, 100, 50, 1'b0);       // already running
    push_req(REQ_START, 5, 100, 50, 1'b0);       // bad channel
    push_req(REQ_STOP, 7, 0, 0, 1'b0);
    push_req(REQ_START, 1, 100, 101, 1'b0);      // duty over range
    push_req(REQ_START, 1, 100, 255, 1'b0);
    push_req(REQ_START, 1, 100, 0, 1'b0);        // zero duty: no change
    push_req(REQ_START, 1, 100, 100, 1'b0);      // full duty: pin high only
    push_req(REQ_STOP, 1, 0, 0, 1'b0);           // cannot stop it
    push_req(REQ_START, 2, 0, 30, 1'b0);         // zero frequency
    push_req(REQ_START, 2, 1000000, 1, 1'b0);    // counts clamp to one
    push_req(REQ_START, 3, 1, 99, 1'b0);
    for (int i = 0; i < 5; i++) push_req(REQ_TICK, i, 0, 0, 1'b0);
    push_req(REQ_STOP, 0, 0, 0, 1'b1);
    push_req(REQ_STOP, 0, 0, 0, 1'b0);
    push_req(REQ_NONE, 3, 0, 0, 1'b0);

    run_phase(1'b1, 1000, 1, 0, 100, 9, 280);
    run_phase(1'b1, 100000000, 1024, 10, 90, 9, 280);
    run_phase(1'b1, 1, 0, 0, 100, 54, 260);      // zero prescale acts as one
    run_phase(1'b0, 1, 1024, 0, 0, 54, 40);
    run_phase(1'b1, 1, 1024, 0, 0, 54, 60);
    run_phase(1'b1, 5000, 3, 100, 100, 0, 180);
    run_phase(1'b1, 20000, 2, 0, 100, 0, 320);

    wait_quiet();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("** multichannel_tick_pwm_generator: PASSED **");
    end else begin
      $display("** multichannel_tick_pwm_generator: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $realtime);
    $display("** multichannel_tick_pwm_generator: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/mctp_pkg.sv
design/mctp_div.sv
design/mctp_ctrl.sv
design/mctp_dp.sv
design/multichannel_tick_pwm_generator.sv
bench/multichannel_tick_pwm_generator_tb.sv
